/* rtl/rttp_pkg.sv */
// ----------------------------------------------------------------------------
// Ring-tone note parser package
// Shared widths, register indexes, character codes and the note record type.
// ----------------------------------------------------------------------------
`default_nettype none

package rttp_pkg;

   // Field widths
   localparam int CH_W       = 8;
   localparam int TONE_W     = 8;
   localparam int BEAT_W     = 16;
   localparam int DIGITS_W   = 16;
   localparam int SEMI_W     = 4;
   localparam int OCT_W      = 4;
   localparam int DUR_W      = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WHOLE_NOTE_MS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEFAULT_DURATION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEFAULT_OCTAVE   = 2'd2;

   // Reset values of the configuration registers
   localparam logic [BEAT_W-1:0] WHOLE_NOTE_RST = 16'd2400;
   localparam logic [DUR_W-1:0]  DEF_DUR_RST    = 6'd4;
   localparam logic [OCT_W-1:0]  DEF_OCT_RST    = 4'd5;

   // Octave that maps to tone offset zero
   localparam logic [TONE_W-1:0] BASE_OCTAVE    = 8'd4;
   localparam logic [TONE_W-1:0] SEMIS_PER_OCT  = 8'd12;

   // Character codes
   localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
   localparam logic [CH_W-1:0] CH_SHARP = 8'h23;
   localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CH_A     = 8'h61;
   localparam logic [CH_W-1:0] CH_B     = 8'h62;
   localparam logic [CH_W-1:0] CH_C     = 8'h63;
   localparam logic [CH_W-1:0] CH_D     = 8'h64;
   localparam logic [CH_W-1:0] CH_E     = 8'h65;
   localparam logic [CH_W-1:0] CH_F     = 8'h66;
   localparam logic [CH_W-1:0] CH_G     = 8'h67;

   // One pending note waiting for the divider
   typedef struct packed {
      logic [DIGITS_W-1:0] digits;
      logic [SEMI_W-1:0]   semi;
      logic                dotted;
      logic [OCT_W-1:0]    octave;
      logic                last;
      logic                done;
   } note_type;

   // Semitone of a note letter; anything else is a rest
   function automatic logic [SEMI_W-1:0] letter_semi(input logic [CH_W-1:0] c);
      logic [SEMI_W-1:0] s;
      begin
         case (c)
            CH_C:    s = 4'd1;
            CH_D:    s = 4'd3;
            CH_E:    s = 4'd5;
            CH_F:    s = 4'd6;
            CH_G:    s = 4'd8;
            CH_A:    s = 4'd10;
            CH_B:    s = 4'd12;
            default: s = 4'd0;
         endcase
         return s;
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/rttp_channels.sv */
// ----------------------------------------------------------------------------
// Ring-tone note parser channels
// Valid/ready interfaces for the byte input, note output and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rttp_req_if;
   import rttp_pkg::*;
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;
   logic            end_of_tune;
   modport source (output valid, output ch, output end_of_tune, input ready);
   modport sink   (input valid, input ch, input end_of_tune, output ready);
endinterface

interface rttp_rsp_if;
   import rttp_pkg::*;
   logic              valid;
   logic              ready;
   logic [TONE_W-1:0] tone;
   logic [BEAT_W-1:0] beat;
   logic              last_of_run;
   logic              tune_done;
   modport source (output valid, output tone, output beat, output last_of_run,
                   output tune_done, input ready);
   modport sink   (input valid, input tone, input beat, input last_of_run,
                   input tune_done, output ready);
endinterface

interface rttp_csr_if;
   import rttp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/ring_tone_note_parser_core.sv */
// ----------------------------------------------------------------------------
// Ring-tone note parser core
// Parses ring-tone text byte by byte and emits tone/beat records per note.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch : one text byte per item plus an end-of-tune flag. The header
//            (name and defaults) up to the second colon is skipped.
//   rsp_ch : one item per note: tone number, beat in ms, last_of_run on the
//            final item caused by a byte, tune_done on the tune's final note.
//   csr_ch : register writes (whole note ms, default duration, default
//            octave); always ready, write only while the core is idle.
// Flow:
//   A byte that ends no note leaves req_ch ready. A byte that ends one
//   or two notes holds off req_ch while each note goes through the shared
//   restoring divider: a load step, one divide step per quotient bit,
//   and a step that applies the dot and forms the tone. The next byte
//   is taken only once each note that the byte ends has gone out on
//   rsp_ch. A receiver stall holds the item and the core.
// Reset:
//   Registers return to 2400 / 4 / 5, the parser to the header phase and
//   no item is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_tone_note_parser_core (
   input  wire logic   clock,
   input  wire logic   reset,
   rttp_req_if.sink    req_ch,
   rttp_rsp_if.source  rsp_ch,
   rttp_csr_if.sink    csr_ch
);
   import rttp_pkg::*;

   // Parse phases
   localparam logic [2:0] PH_HEADER       = 3'd0;
   localparam logic [2:0] PH_DUR_EMPTY    = 3'd1;
   localparam logic [2:0] PH_DUR_DIGITS   = 3'd2;
   localparam logic [2:0] PH_AFTER_LETTER = 3'd3;
   localparam logic [2:0] PH_AFTER_SHARP  = 3'd4;
   localparam logic [2:0] PH_AFTER_DOT    = 3'd5;
   localparam logic [2:0] PH_AFTER_OCT    = 3'd6;

   // Sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOAD = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   // Configuration registers
   logic [BEAT_W-1:0]   whole_ff;
   logic [DUR_W-1:0]    def_dur_ff;
   logic [OCT_W-1:0]    def_oct_ff;

   // Parser state
   logic [2:0]          phase_ff, phase_in;
   logic [1:0]          colons_ff, colons_in;
   logic [DIGITS_W-1:0] digits_ff, digits_in;
   logic [SEMI_W-1:0]   semi_ff, semi_in;
   logic                dot_ff, dot_in;
   logic [OCT_W-1:0]    oct_ff, oct_in;

   // Sequencer and divider
   logic [1:0]          st_ff;
   note_type            job0_ff, job1_ff;
   logic                has1_ff;
   logic [3:0]          cnt_ff;
   logic [BEAT_W-1:0]   rem_ff, quo_ff, dvsr_ff;
   logic                fin_ff;

   // Output register
   logic                rsp_valid_ff;
   logic [TONE_W-1:0]   tone_ff;
   logic [BEAT_W-1:0]   beat_ff;
   logic                last_ff, done_ff;

   logic                req_acc;
   logic                emit_a, emit_b, do_start, is_dig;
   note_type            note_a, note_b;
   logic [CH_W-1:0]     c;

   assign req_ch.ready = (st_ff == S_IDLE);
   assign req_acc      = req_ch.valid & req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.tone        = tone_ff;
   assign rsp_ch.beat        = beat_ff;
   assign rsp_ch.last_of_run = last_ff;
   assign rsp_ch.tune_done   = done_ff;

   // Parse one byte: next parser state and the notes it ends
   always_comb begin
      c         = req_ch.ch;
      phase_in  = phase_ff;
      colons_in = colons_ff;
      digits_in = digits_ff;
      semi_in   = semi_ff;
      dot_in    = dot_ff;
      oct_in    = oct_ff;
      emit_a    = 1'b0;
      emit_b    = 1'b0;
      do_start  = 1'b0;
      is_dig    = (c >= CH_ZERO) && (c <= CH_NINE);
      note_a    = '{digits: digits_ff, semi: semi_ff, dotted: dot_ff, octave: oct_ff,
                    last: 1'b0, done: 1'b0};

      if (phase_ff == PH_HEADER) begin
         if (c == CH_COLON) begin
            colons_in = colons_ff + 2'd1;
            if (colons_in >= 2'd2) begin
               colons_in = 2'd0;
               phase_in  = PH_DUR_EMPTY;
               digits_in = '0;
               semi_in   = '0;
               dot_in    = 1'b0;
               oct_in    = def_oct_ff;
            end
         end
      end else if (phase_ff == PH_DUR_EMPTY || phase_ff == PH_DUR_DIGITS) begin
         do_start = 1'b1;
      end else if (phase_ff == PH_AFTER_LETTER && c == CH_SHARP) begin
         semi_in  = semi_ff + 4'd1;
         phase_in = PH_AFTER_SHARP;
      end else if (phase_ff <= PH_AFTER_SHARP && c == CH_DOT) begin
         dot_in   = 1'b1;
         phase_in = PH_AFTER_DOT;
      end else if (phase_ff <= PH_AFTER_DOT && is_dig) begin
         oct_in   = c[OCT_W-1:0];
         phase_in = PH_AFTER_OCT;
      end else begin
         // Close the current note; a byte other than comma opens the next
         emit_a    = 1'b1;
         digits_in = '0;
         semi_in   = '0;
         dot_in    = 1'b0;
         oct_in    = def_oct_ff;
         phase_in  = PH_DUR_EMPTY;
         do_start  = (c != CH_COMMA);
      end

      // Start of a note: duration digit or letter
      if (do_start) begin
         if (is_dig) begin
            digits_in = (digits_in << 3) + (digits_in << 1)
                      + {{(DIGITS_W-4){1'b0}}, c[3:0]};
            phase_in  = PH_DUR_DIGITS;
         end else begin
            semi_in  = letter_semi(c);
            oct_in   = def_oct_ff;
            phase_in = PH_AFTER_LETTER;
         end
      end

      note_b = '{digits: digits_in, semi: semi_in, dotted: dot_in, octave: oct_in,
                 last: 1'b0, done: 1'b0};

      // End of tune: flush the pending note and go back to the header
      if (req_ch.end_of_tune) begin
         emit_b    = (phase_in >= PH_DUR_DIGITS);
         phase_in  = PH_HEADER;
         colons_in = 2'd0;
         digits_in = '0;
         semi_in   = '0;
         dot_in    = 1'b0;
         oct_in    = def_oct_ff;
      end

      note_b.last = 1'b1;
      note_b.done = req_ch.end_of_tune;
      note_a.last = !emit_b;
      note_a.done = req_ch.end_of_tune && !emit_b;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         whole_ff   <= WHOLE_NOTE_RST;
         def_dur_ff <= DEF_DUR_RST;
         def_oct_ff <= DEF_OCT_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_WHOLE_NOTE_MS:    whole_ff   <= csr_ch.data;
            REG_DEFAULT_DURATION: def_dur_ff <= csr_ch.data[DUR_W-1:0];
            REG_DEFAULT_OCTAVE:   def_oct_ff <= csr_ch.data[OCT_W-1:0];
            default: ;
         endcase
      end
   end

   // Parser state update
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         colons_ff <= 2'd0;
         digits_ff <= '0;
         semi_ff   <= '0;
         dot_ff    <= 1'b0;
         oct_ff    <= DEF_OCT_RST;
      end else if (req_acc) begin
         phase_ff  <= phase_in;
         colons_ff <= colons_in;
         digits_ff <= digits_in;
         semi_ff   <= semi_in;
         dot_ff    <= dot_in;
         oct_ff    <= oct_in;
      end
   end

   // Divider step and output formatting
   logic [BEAT_W:0]     shifted;
   logic [BEAT_W+1:0]   diff;
   logic                borrow;
   logic [BEAT_W-1:0]   beat_val;
   logic [TONE_W-1:0]   oct_ofs;
   logic [TONE_W-1:0]   tone_val;

   always_comb begin
      shifted  = {rem_ff, quo_ff[BEAT_W-1]};
      diff     = {1'b0, shifted} - {2'b00, dvsr_ff};
      borrow   = diff[BEAT_W+1];
      beat_val = job0_ff.dotted ? quo_ff + (quo_ff >> 1) : quo_ff;
      oct_ofs  = {{(TONE_W-OCT_W){1'b0}}, job0_ff.octave} - BASE_OCTAVE;
      tone_val = (job0_ff.semi == '0) ? '0
               : TONE_W'(oct_ofs * SEMIS_PER_OCT)
                 + {{(TONE_W-SEMI_W){1'b0}}, job0_ff.semi};
   end

   // Sequencer: load, divide bit by bit, format, hand off
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         has1_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fin_ff       <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         unique case (st_ff)
            S_IDLE: begin
               if (req_acc && (emit_a || emit_b)) begin
                  job0_ff <= emit_a ? note_a : note_b;
                  job1_ff <= note_b;
                  has1_ff <= emit_a && emit_b;
                  st_ff   <= S_LOAD;
               end
            end
            S_LOAD: begin
               // Zero divisor falls out as an all-ones quotient
               dvsr_ff <= (job0_ff.digits != '0) ? job0_ff.digits
                        : {{(BEAT_W-DUR_W){1'b0}}, def_dur_ff};
               rem_ff  <= '0;
               quo_ff  <= whole_ff;
               cnt_ff  <= '0;
               fin_ff  <= 1'b0;
               st_ff   <= S_DIV;
            end
            S_DIV: begin
               if (!fin_ff) begin
                  if (borrow) begin
                     rem_ff <= shifted[BEAT_W-1:0];
                     quo_ff <= {quo_ff[BEAT_W-2:0], 1'b0};
                  end else begin
                     rem_ff <= diff[BEAT_W-1:0];
                     quo_ff <= {quo_ff[BEAT_W-2:0], 1'b1};
                  end
                  cnt_ff <= cnt_ff + 4'd1;
                  fin_ff <= (cnt_ff == 4'd15);
               end else begin
                  tone_ff      <= tone_val;
                  beat_ff      <= beat_val;
                  last_ff      <= job0_ff.last;
                  done_ff      <= job0_ff.done;
                  rsp_valid_ff <= 1'b1;
                  st_ff        <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (has1_ff) begin
                     job0_ff <= job1_ff;
                     has1_ff <= 1'b0;
                     st_ff   <= S_LOAD;
                  end else begin
                     st_ff <= S_IDLE;
                  end
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire
